/* src/ffpa_pkg.sv */
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants for the first-fit / paged allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int SIZE_W   = 11;
	localparam int OID_W    = 16;
	localparam int PIDX_W   = 6;
	localparam int STATUS_W = 2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOID    = 2'd2;

	localparam logic [1:0] FSM_IDLE = 2'd0;
	localparam logic [1:0] FSM_P1   = 2'd1;
	localparam logic [1:0] FSM_P2   = 2'd2;
	localparam logic [1:0] FSM_HOLD = 2'd3;

endpackage

/* src/first_fit_and_paged_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_and_paged_allocator
// Unit map held in a ring of cells rotated past one head processor.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  req     | req_valid req_ready kind paged_req size   | in
//          | owner_to_free                             |
//  rsp     | rsp_valid rsp_ready status owner_id       | out
//
//  A request runs two full rotations of the ring, one unit through the head
//  per cycle. Pass one frees, finds a run or marks free pages; pass two writes
//  the claim. The result is written to the output register after pass two
//  ends, and the next request is taken only after that, so a new request
//  waits until the last one is through. No clearing pass after reset.
//  A stalled response keeps the block waiting until the output register frees.
module first_fit_and_paged_allocator import ffpa_pkg::*; #(
	parameter int MEMORY_UNITS = 1024,
	parameter int PAGE_UNITS   = 16,
	parameter int ID_BITS      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                kind,
	input  logic                paged_req,
	input  logic [SIZE_W-1:0]   size,
	input  logic [OID_W-1:0]    owner_to_free,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [OID_W-1:0]    owner_id
);

	localparam int N   = MEMORY_UNITS;
	localparam int P   = PAGE_UNITS;
	localparam int AW  = $clog2(N);
	localparam int PW  = (P > 1) ? $clog2(P) : 1;
	localparam int LW0 = $clog2(N + P + 1);
	localparam int LW  = ((LW0 > SIZE_W) ? LW0 : SIZE_W) + 1;
	localparam int CW  = (ID_BITS > OID_W) ? ID_BITS : OID_W;
	localparam int TAP = (P <= N) ? P - 1 : 0;

	logic               used_w  [N];
	logic [ID_BITS-1:0] owner_w [N];
	logic               paged_w [N];
	logic [PIDX_W-1:0]  pidx_w  [N];
	logic               mark_w  [N];

	logic               h_used, h_paged, h_mark;
	logic [ID_BITS-1:0] h_owner;
	logic [PIDX_W-1:0]  h_pidx;
	logic               shift;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			if (gi < N - 1) begin : g_mid
				ffpa_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.used_d(used_w[gi+1]), .owner_d(owner_w[gi+1]),
					.paged_d(paged_w[gi+1]), .pidx_d(pidx_w[gi+1]),
					.mark_d(mark_w[gi+1]),
					.used(used_w[gi]), .owner(owner_w[gi]), .paged(paged_w[gi]),
					.pidx(pidx_w[gi]), .mark(mark_w[gi])
				);
			end else begin : g_last
				ffpa_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.used_d(h_used), .owner_d(h_owner),
					.paged_d(h_paged), .pidx_d(h_pidx), .mark_d(h_mark),
					.used(used_w[gi]), .owner(owner_w[gi]), .paged(paged_w[gi]),
					.pidx(pidx_w[gi]), .mark(mark_w[gi])
				);
			end
		end
	endgenerate

	logic [1:0]          state_q;
	logic [AW-1:0]       cnt_q;
	logic [PW-1:0]       off_q;
	logic [ID_BITS:0]    idc_q;
	logic                kind_q, paging_q;
	logic [LW-1:0]       len_q;
	logic [OID_W-1:0]    victim_q;
	logic [LW-1:0]       run_q, start_q, end_q, taken_q;
	logic                found_q, pgfree_q, take_q;
	logic [PIDX_W-1:0]   rank_q, prank_q;

	logic                exh, last_unit, page_end, pg_free, page_take, ok;
	logic [PIDX_W-1:0]   page_rank;
	logic [LW-1:0]       t_ext, run_nx;
	logic [ID_BITS-1:0]  id_now;

	assign shift     = (state_q == FSM_P1) || (state_q == FSM_P2);
	assign exh       = idc_q[ID_BITS];
	assign id_now    = idc_q[ID_BITS-1:0];
	assign last_unit = (cnt_q == AW'(N - 1));
	assign page_end  = (off_q == PW'(P - 1)) && (P <= N);
	assign t_ext     = LW'(cnt_q);
	assign run_nx    = used_w[0] ? '0 : run_q + LW'(1);
	assign pg_free   = ((off_q == '0) ? 1'b1 : pgfree_q) & !used_w[0];
	assign page_take = (off_q == '0) ? mark_w[TAP] : take_q;
	assign page_rank = (off_q == '0) ? pidx_w[TAP] : prank_q;
	assign ok        = paging_q ? (taken_q >= len_q) : found_q;

	always_comb begin
		h_used  = used_w[0];
		h_owner = owner_w[0];
		h_paged = paged_w[0];
		h_pidx  = pidx_w[0];
		h_mark  = mark_w[0];
		if (state_q == FSM_P1) begin
			if (kind_q == KIND_FREE) begin
				if (used_w[0] && (CW'(owner_w[0]) == CW'(victim_q))) begin
					h_used  = 1'b0;
					h_owner = '0;
					h_paged = 1'b0;
					h_pidx  = '0;
				end
			end else if (!exh && paging_q && page_end && pg_free && (taken_q < len_q)) begin
				h_mark = 1'b1;
				h_pidx = rank_q;
			end
		end else if (state_q == FSM_P2 && kind_q == KIND_ALLOC && !exh) begin
			if (paging_q) begin
				h_mark = 1'b0;
				if (page_take) begin
					if (ok) begin
						h_used  = 1'b1;
						h_owner = id_now;
						h_paged = 1'b1;
						h_pidx  = page_rank;
					end else begin
						h_pidx = '0;
					end
				end
			end else if (found_q && t_ext >= start_q && t_ext <= end_q) begin
				h_used  = 1'b1;
				h_owner = id_now;
				h_paged = 1'b0;
				h_pidx  = '0;
			end
		end
	end

	assign req_ready = (state_q == FSM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			idc_q     <= (ID_BITS+1)'(1);
			rsp_valid <= 1'b0;
			cnt_q     <= '0;
			off_q     <= '0;
		end else begin
			if (rsp_valid && rsp_ready && state_q != FSM_HOLD)
				rsp_valid <= 1'b0;
			if (shift) begin
				cnt_q <= last_unit ? '0 : cnt_q + AW'(1);
				off_q <= (last_unit || off_q == PW'(P - 1)) ? '0 : off_q + PW'(1);
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (req_valid)
						state_q <= FSM_P1;
				end
				FSM_P1: begin
					if (last_unit)
						state_q <= FSM_P2;
				end
				FSM_P2: begin
					if (last_unit)
						state_q <= FSM_HOLD;
				end
				FSM_HOLD: begin
					if (!rsp_valid || rsp_ready) begin
						rsp_valid <= 1'b1;
						state_q   <= FSM_IDLE;
						if (kind_q == KIND_ALLOC && !exh && ok)
							idc_q <= idc_q + (ID_BITS+1)'(1);
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && req_valid) begin
			kind_q   <= kind;
			paging_q <= paged_req;
			len_q    <= LW'(size);
			victim_q <= owner_to_free;
			run_q    <= '0;
			found_q  <= 1'b0;
			taken_q  <= '0;
			rank_q   <= '0;
			pgfree_q <= 1'b1;
		end
		if (state_q == FSM_P1) begin
			run_q    <= run_nx;
			pgfree_q <= pg_free;
			if (!found_q && !used_w[0] && len_q != '0 && run_nx == len_q) begin
				found_q <= 1'b1;
				end_q   <= t_ext;
				start_q <= t_ext + LW'(1) - len_q;
			end
			if (paging_q && page_end && pg_free && (taken_q < len_q)) begin
				taken_q <= taken_q + LW'(P);
				rank_q  <= rank_q + PIDX_W'(1);
			end
		end
		if (state_q == FSM_P2 && off_q == '0) begin
			take_q  <= mark_w[TAP];
			prank_q <= pidx_w[TAP];
		end
		if (state_q == FSM_HOLD && (!rsp_valid || rsp_ready)) begin
			if (kind_q == KIND_FREE) begin
				status   <= ST_DONE;
				owner_id <= '0;
			end else if (exh) begin
				status   <= ST_NOID;
				owner_id <= '0;
			end else if (ok) begin
				status   <= ST_DONE;
				owner_id <= OID_W'(CW'(id_now));
			end else begin
				status   <= ST_NOSPACE;
				owner_id <= '0;
			end
		end
	end

endmodule

/* src/ffpa_cell.sv */
// ----------------------------------------------------------------------------
// ffpa_cell
// One memory unit of the ring; loads its neighbor's unit on every shift.
// ----------------------------------------------------------------------------
module ffpa_cell import ffpa_pkg::*; #(
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  logic               used_d,
	input  logic [ID_BITS-1:0] owner_d,
	input  logic               paged_d,
	input  logic [PIDX_W-1:0]  pidx_d,
	input  logic               mark_d,
	output logic               used,
	output logic [ID_BITS-1:0] owner,
	output logic               paged,
	output logic [PIDX_W-1:0]  pidx,
	output logic               mark
);

	logic               used_q, paged_q, mark_q;
	logic [ID_BITS-1:0] owner_q;
	logic [PIDX_W-1:0]  pidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (shift) begin
			used_q <= used_d;
			mark_q <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			owner_q <= owner_d;
			paged_q <= paged_d;
			pidx_q  <= pidx_d;
		end
	end

	assign used  = used_q;
	assign owner = owner_q;
	assign paged = paged_q;
	assign pidx  = pidx_q;
	assign mark  = mark_q;

endmodule

/* bench/ffpa_checker.sv */
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches the request and response channels of the allocator, keeps its own
// copy of the unit map and id counter, predicts each response and compares.
// ----------------------------------------------------------------------------
module ffpa_checker import ffpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                kind,
	input  logic                paged_req,
	input  logic [SIZE_W-1:0]   size,
	input  logic [OID_W-1:0]    owner_to_free,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic [STATUS_W-1:0] status,
	input  logic [OID_W-1:0]    owner_id,
	output int                  errors,
	output int                  pending,
	output logic [OID_W:0]      next_id,
	output int                  n_granted,
	output int                  n_nospace,
	output int                  n_freed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNITS = 1024;
	localparam int PAGE  = 16;
	localparam int PAGES = UNITS / PAGE;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [OID_W-1:0]    oid;
	} grant_t;

	logic             unit_busy [UNITS];
	logic [OID_W-1:0] unit_owner[UNITS];
	logic [OID_W:0]   id_ctr;
	grant_t           grants_due[$];

	assign pending = grants_due.size();
	assign next_id = id_ctr;

	function automatic bit page_is_open(int pg);
		for (int j = 0; j < PAGE; j++)
			if (unit_busy[pg*PAGE + j])
				return 0;
		return 1;
	endfunction

	task automatic claim(int u, logic [OID_W-1:0] id);
		unit_busy[u]  = 1'b1;
		unit_owner[u] = id;
	endtask

	task automatic serve_request(input logic k, input logic pg_mode,
			input logic [SIZE_W-1:0] sz, input logic [OID_W-1:0] victim,
			output grant_t g);
		int  run;
		int  start;
		int  need;
		int  found;
		int  rank;
		bit  ok;
		g = '{st: ST_DONE, oid: '0};
		ok = 0;
		start = -1;
		if (k == KIND_FREE) begin
			n_freed++;
			for (int i = 0; i < UNITS; i++)
				if (unit_busy[i] && unit_owner[i] == victim) begin
					unit_busy[i]  = 1'b0;
					unit_owner[i] = '0;
				end
		end else if (id_ctr > 17'h0FFFF) begin
			g.st = ST_NOID;
		end else begin
			if (pg_mode) begin
				need = (int'(sz) + PAGE - 1) / PAGE;
				found = 0;
				for (int p = 0; p < PAGES; p++)
					if (page_is_open(p))
						found++;
				if (found >= need) begin
					ok = 1;
					rank = 0;
					for (int p = 0; p < PAGES && rank < need; p++)
						if (page_is_open(p)) begin
							for (int j = 0; j < PAGE; j++)
								claim(p*PAGE + j, id_ctr[OID_W-1:0]);
							rank++;
						end
				end
			end else if (sz != 0) begin
				run = 0;
				for (int i = 0; i < UNITS && start < 0; i++) begin
					if (unit_busy[i])
						run = 0;
					else begin
						run++;
						if (run == int'(sz))
							start = i + 1 - run;
					end
				end
				if (start >= 0) begin
					ok = 1;
					for (int i = start; i < start + int'(sz); i++)
						claim(i, id_ctr[OID_W-1:0]);
				end
			end
			if (ok) begin
				g.oid = id_ctr[OID_W-1:0];
				id_ctr++;
				n_granted++;
			end else begin
				g.st = ST_NOSPACE;
				n_nospace++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			for (int i = 0; i < UNITS; i++) begin
				unit_busy[i]  = 1'b0;
				unit_owner[i] = '0;
			end
			id_ctr = (OID_W+1)'(1);
			grants_due.delete();
			errors = 0;
			n_granted = 0;
			n_nospace = 0;
			n_freed = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (grants_due.size() == 0) begin
					$error("response transfer with nothing expected");
					errors++;
				end else begin
					g = grants_due.pop_front();
					if (status !== g.st) begin
						$error("status: expected %0d, got %0d", g.st, status);
						errors++;
					end
					if (owner_id !== g.oid) begin
						$error("owner_id: expected %0d, got %0d", g.oid, owner_id);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				serve_request(kind, paged_req, size, owner_to_free, g);
				grants_due.push_back(g);
			end
		end
	end
endmodule

/* bench/first_fit_and_paged_allocator_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_and_paged_allocator_tb
// Drives allocate and free requests into the allocator with random gaps and
// response stalls, one long stall among them; the checker predicts results.
// ----------------------------------------------------------------------------
module first_fit_and_paged_allocator_tb import ffpa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM  = 270;
	localparam int IDLE_STOP = 40000;
	localparam int SQUEEZE   = 6000;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic                kind;
	logic                paged_req;
	logic [SIZE_W-1:0]   size;
	logic [OID_W-1:0]    owner_to_free;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [STATUS_W-1:0] status;
	logic [OID_W-1:0]    owner_id;

	int             errors;
	int             pending;
	logic [OID_W:0] next_id;
	int             n_granted;
	int             n_nospace;
	int             n_freed;
	int             idle_cycles;
	bit             squeeze_req;

	first_fit_and_paged_allocator i_dut (.*);

	ffpa_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	task automatic send(logic k, logic p, logic [SIZE_W-1:0] s, logic [OID_W-1:0] o);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		kind          <= k;
		paged_req     <= p;
		size          <= s;
		owner_to_free <= o;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// receiver side
	initial begin
		int hold;
		hold = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = SQUEEZE;
			end else if (hold == 0)
				hold = pick_gap();
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= 1'b1;
		end
	end

	// watchdog on transfers
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= IDLE_STOP) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int r;
		logic              p;
		logic [SIZE_W-1:0] s;
		logic [OID_W-1:0]  o;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		kind          = KIND_ALLOC;
		paged_req     = 1'b0;
		size          = '0;
		owner_to_free = '0;
		squeeze_req   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(KIND_ALLOC, 1'b0, 11'd0, 16'd0);
		send(KIND_ALLOC, 1'b0, 11'd1, 16'd0);
		send(KIND_ALLOC, 1'b0, 11'h7FF, 16'hFFFF);
		send(KIND_ALLOC, 1'b0, 11'd1024, 16'd0);
		send(KIND_FREE, 1'b0, 11'd0, 16'd1);
		send(KIND_ALLOC, 1'b0, 11'd1024, 16'd0);
		send(KIND_ALLOC, 1'b1, 11'd0, 16'd0);
		send(KIND_ALLOC, 1'b1, 11'd16, 16'd0);
		send(KIND_ALLOC, 1'b0, 11'd1, 16'd0);
		send(KIND_FREE, 1'b1, 11'h7FF, 16'd2);
		send(KIND_ALLOC, 1'b1, 11'd1, 16'd0);
		send(KIND_ALLOC, 1'b1, 11'd17, 16'd0);
		send(KIND_ALLOC, 1'b1, 11'd1024, 16'd0);
		send(KIND_ALLOC, 1'b1, 11'd976, 16'd0);
		send(KIND_ALLOC, 1'b0, 11'd5, 16'd0);
		send(KIND_FREE, 1'b0, 11'd0, 16'd0);
		send(KIND_FREE, 1'b0, 11'd0, 16'hFFFF);
		send(KIND_FREE, 1'b0, 11'd0, 16'd4);
		send(KIND_FREE, 1'b0, 11'd0, 16'd6);
		send(KIND_ALLOC, 1'b0, 11'd20, 16'd0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2)
				squeeze_req = 1'b1;
			r = $urandom_range(0, 99);
			p = ($urandom_range(0, 2) == 0);
			if (r < 40) begin
				if ($urandom_range(0, 9) == 0)
					o = OID_W'($urandom);
				else
					o = OID_W'($urandom_range(1, int'(next_id)));
				send(KIND_FREE, p, SIZE_W'($urandom), o);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					s = SIZE_W'($urandom_range(1, 48));
				else if (r < 90)
					s = SIZE_W'($urandom_range(49, 256));
				else if (r < 97)
					s = SIZE_W'($urandom_range(257, 1024));
				else
					s = SIZE_W'($urandom_range(0, 2047));
				send(KIND_ALLOC, p, s, OID_W'($urandom));
			end
		end
		req_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (2100) @(posedge clk);

		$display("Covered %0d grants, %0d no-space results and %0d frees,",
			n_granted, n_nospace, n_freed);
		$display("contiguous and paged, with gaps and one long response stall.");
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* sim.f */
src/ffpa_pkg.sv
src/ffpa_cell.sv
src/first_fit_and_paged_allocator.sv
bench/ffpa_checker.sv
bench/first_fit_and_paged_allocator_tb.sv
